FILE: src/dcsp_pkg.sv
// Shared types, opcode and result codes, and the parameter-length table
// for the DVI command stream parser. No dependencies.
`default_nettype none

package dcsp_pkg;

    // Opcodes that open the ranges of the DVI command set.
    localparam logic [7:0] OP_SET1         = 8'd128;
    localparam logic [7:0] OP_SET_RULE     = 8'd132;
    localparam logic [7:0] OP_PUT1         = 8'd133;
    localparam logic [7:0] OP_PUT_RULE     = 8'd137;
    localparam logic [7:0] OP_BOP          = 8'd139;
    localparam logic [7:0] OP_RIGHT1       = 8'd143;
    localparam logic [7:0] OP_W1           = 8'd148;
    localparam logic [7:0] OP_X1           = 8'd153;
    localparam logic [7:0] OP_DOWN1        = 8'd157;
    localparam logic [7:0] OP_Y1           = 8'd162;
    localparam logic [7:0] OP_Z1           = 8'd167;
    localparam logic [7:0] OP_FNT1         = 8'd235;
    localparam logic [7:0] OP_XXX1         = 8'd239;
    localparam logic [7:0] OP_FNT_DEF1     = 8'd243;
    localparam logic [7:0] OP_PRE          = 8'd247;
    localparam logic [7:0] OP_POST         = 8'd248;
    localparam logic [7:0] OP_POST_POST    = 8'd249;
    localparam logic [7:0] OP_FIRST_UNDEF  = 8'd250;

    // Width of a four-way opcode group minus one.
    localparam logic [7:0] GROUP_SPAN      = 8'd3;

    // Parameter slots with special meaning.
    localparam logic [3:0] SLOT_BOP_P      = 4'd10;
    localparam logic [3:0] SLOT_FNT_AREA   = 4'd4;
    localparam logic [3:0] SLOT_FNT_NAME   = 4'd5;
    localparam logic [3:0] SLOT_PRE_K      = 4'd4;
    localparam logic [3:0] SLOT_PP_ID      = 4'd1;

    // Required DVI id byte.
    localparam logic [31:0] DVI_ID         = 32'd2;

    // Result kinds.
    localparam logic [1:0] KIND_CMD        = 2'd0;
    localparam logic [1:0] KIND_PARAM      = 2'd1;
    localparam logic [1:0] KIND_TEXT       = 2'd2;
    localparam logic [1:0] KIND_ERROR      = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNDEF_OP    = 2'd1;
    localparam logic [1:0] ERR_BAD_ID      = 2'd2;
    localparam logic [1:0] ERR_PAGE_PTR    = 2'd3;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_PARAM,
        PH_TEXT
    } t_phase;

    typedef struct packed {
        logic [2:0] len;
        logic       sgn;
    } t_plen;

    typedef struct packed {
        logic [7:0]         opcode;
        logic [1:0]         kind;
        logic [3:0]         param_index;
        logic signed [31:0] value;
        logic [7:0]         text_byte;
        logic [1:0]         error_code;
        logic [15:0]        page_count;
        logic [31:0]        command_position;
        logic               last;
    } t_result;

    function automatic logic in_group(input logic [7:0] op, input logic [7:0] base);
        in_group = (op >= base) && (op <= base + GROUP_SPAN);
    endfunction

    // Byte length (zero when the slot does not exist) and signedness of a
    // parameter slot of a command.
    function automatic t_plen param_len(input logic [7:0] op, input logic [3:0] slot);
        t_plen r;
        r.len = 3'd0;
        r.sgn = 1'b1;
        if (in_group(op, OP_SET1) || in_group(op, OP_PUT1) || in_group(op, OP_FNT1)) begin
            if (in_group(op, OP_FNT1)) begin
                r.len = 3'(op - OP_FNT1 + 8'd1);
            end else if (in_group(op, OP_PUT1)) begin
                r.len = 3'(op - OP_PUT1 + 8'd1);
            end else begin
                r.len = 3'(op - OP_SET1 + 8'd1);
            end
            r.sgn = (r.len == 3'd4);
            if (slot != 4'd0) begin
                r.len = 3'd0;
            end
        end else if (op == OP_SET_RULE || op == OP_PUT_RULE) begin
            r.len = (slot < 4'd2) ? 3'd4 : 3'd0;
        end else if (op == OP_BOP) begin
            r.len = (slot <= SLOT_BOP_P) ? 3'd4 : 3'd0;
        end else if (in_group(op, OP_RIGHT1)) begin
            r.len = (slot == 4'd0) ? 3'(op - OP_RIGHT1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_W1)) begin
            r.len = (slot == 4'd0) ? 3'(op - OP_W1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_X1)) begin
            r.len = (slot == 4'd0) ? 3'(op - OP_X1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_DOWN1)) begin
            r.len = (slot == 4'd0) ? 3'(op - OP_DOWN1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_Y1)) begin
            r.len = (slot == 4'd0) ? 3'(op - OP_Y1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_Z1)) begin
            r.len = (slot == 4'd0) ? 3'(op - OP_Z1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_XXX1)) begin
            r.sgn = 1'b0;
            r.len = (slot == 4'd0) ? 3'(op - OP_XXX1 + 8'd1) : 3'd0;
        end else if (in_group(op, OP_FNT_DEF1)) begin
            if (slot == 4'd0) begin
                r.sgn = (op == OP_FNT_DEF1 + GROUP_SPAN);
                r.len = 3'(op - OP_FNT_DEF1 + 8'd1);
            end else if (slot == 4'd1) begin
                r.sgn = 1'b0;
                r.len = 3'd4;
            end else if (slot <= 4'd3) begin
                r.len = 3'd4;
            end else if (slot <= SLOT_FNT_NAME) begin
                r.sgn = 1'b0;
                r.len = 3'd1;
            end
        end else if (op == OP_PRE) begin
            if (slot == 4'd0 || slot == SLOT_PRE_K) begin
                r.sgn = 1'b0;
                r.len = 3'd1;
            end else if (slot <= 4'd3) begin
                r.len = 3'd4;
            end
        end else if (op == OP_POST) begin
            if (slot <= 4'd5) begin
                r.len = 3'd4;
            end else if (slot <= 4'd7) begin
                r.sgn = 1'b0;
                r.len = 3'd2;
            end
        end else if (op == OP_POST_POST) begin
            r.sgn = 1'b0;
            if (slot == 4'd0) begin
                r.len = 3'd4;
            end else if (slot == SLOT_PP_ID) begin
                r.len = 3'd1;
            end
        end
        param_len = r;
    endfunction

endpackage

`default_nettype wire

FILE: src/dcsp_core.sv
// Decode state machine of the DVI command stream parser: parser state
// registers and the per-byte decode. Depends on dcsp_pkg.
`default_nettype none

module dcsp_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_result_valid,
    output dcsp_pkg::t_result      o_result
);

    dcsp_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [3:0]  r_slot, n_slot;
    logic [2:0]  r_bytes_left, n_bytes_left;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_text_left, n_text_left;
    logic [7:0]  r_area_hold, n_area_hold;
    logic [31:0] r_byte_pos, n_byte_pos;
    logic [31:0] r_cmd_start, n_cmd_start;
    logic [31:0] r_prev_page, n_prev_page;
    logic [15:0] r_pages, n_pages;
    logic        r_halted, n_halted;

    dcsp_pkg::t_plen op_len;
    dcsp_pkg::t_plen cur_len;
    dcsp_pkg::t_plen next_len;
    logic [31:0] acc_shift;
    logic [2:0]  bl_dec;
    logic [31:0] pval;
    logic [31:0] text_dec;
    logic [31:0] text_len;
    logic [3:0]  slot_inc;
    logic        id_check;
    logic        page_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= dcsp_pkg::PH_OPCODE;
            r_opcode     <= '0;
            r_slot       <= '0;
            r_bytes_left <= '0;
            r_acc        <= '0;
            r_text_left  <= '0;
            r_area_hold  <= '0;
            r_byte_pos   <= '0;
            r_cmd_start  <= '0;
            r_prev_page  <= '1;
            r_pages      <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_opcode     <= n_opcode;
            r_slot       <= n_slot;
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_text_left  <= n_text_left;
            r_area_hold  <= n_area_hold;
            r_byte_pos   <= n_byte_pos;
            r_cmd_start  <= n_cmd_start;
            r_prev_page  <= n_prev_page;
            r_pages      <= n_pages;
            r_halted     <= n_halted;
        end
    end

    assign op_len    = dcsp_pkg::param_len(i_data_byte, 4'd0);
    assign cur_len   = dcsp_pkg::param_len(r_opcode, r_slot);
    assign slot_inc  = r_slot + 4'd1;
    assign next_len  = dcsp_pkg::param_len(r_opcode, slot_inc);
    assign acc_shift = {r_acc[23:0], i_data_byte};
    assign bl_dec    = (r_bytes_left != 3'd0) ? r_bytes_left - 3'd1 : 3'd0;
    assign text_dec  = r_text_left - 32'd1;

    // Short signed parameters are sign-extended; unsigned and four-byte ones pass as raw bits.
    always_comb begin
        pval = acc_shift;
        if (cur_len.sgn) begin
            case (cur_len.len)
                3'd1:    pval = {{24{acc_shift[7]}}, acc_shift[7:0]};
                3'd2:    pval = {{16{acc_shift[15]}}, acc_shift[15:0]};
                3'd3:    pval = {{8{acc_shift[23]}}, acc_shift[23:0]};
                default: pval = acc_shift;
            endcase
        end
    end

    assign id_check = (r_opcode == dcsp_pkg::OP_PRE && r_slot == 4'd0) ||
                      (r_opcode == dcsp_pkg::OP_POST_POST && r_slot == dcsp_pkg::SLOT_PP_ID);
    assign page_check = (r_opcode == dcsp_pkg::OP_BOP && r_slot == dcsp_pkg::SLOT_BOP_P) ||
                        (r_opcode == dcsp_pkg::OP_POST && r_slot == 4'd0);

    // Length of the text that follows the current parameter, zero for none.
    always_comb begin
        text_len = 32'd0;
        if (dcsp_pkg::in_group(r_opcode, dcsp_pkg::OP_XXX1) && r_slot == 4'd0) begin
            text_len = pval;
        end else if (dcsp_pkg::in_group(r_opcode, dcsp_pkg::OP_FNT_DEF1) &&
                     r_slot == dcsp_pkg::SLOT_FNT_NAME) begin
            text_len = {24'd0, r_area_hold} + {24'd0, pval[7:0]};
        end else if (r_opcode == dcsp_pkg::OP_PRE && r_slot == dcsp_pkg::SLOT_PRE_K) begin
            text_len = {24'd0, pval[7:0]};
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_opcode     = r_opcode;
        n_slot       = r_slot;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_text_left  = r_text_left;
        n_area_hold  = r_area_hold;
        n_byte_pos   = r_byte_pos;
        n_cmd_start  = r_cmd_start;
        n_prev_page  = r_prev_page;
        n_pages      = r_pages;
        n_halted     = r_halted;

        o_result_valid            = 1'b0;
        o_result.opcode           = r_opcode;
        o_result.kind             = dcsp_pkg::KIND_CMD;
        o_result.param_index      = r_slot;
        o_result.value            = '0;
        o_result.text_byte        = '0;
        o_result.error_code       = dcsp_pkg::ERR_NONE;
        o_result.page_count       = r_pages;
        o_result.command_position = r_cmd_start;
        o_result.last             = 1'b0;

        if (i_accept && !r_halted) begin
            n_byte_pos = r_byte_pos + 32'd1;
            case (r_phase)
                dcsp_pkg::PH_TEXT: begin
                    n_text_left        = text_dec;
                    o_result_valid     = 1'b1;
                    o_result.kind      = dcsp_pkg::KIND_TEXT;
                    o_result.text_byte = i_data_byte;
                    o_result.last      = (text_dec == 32'd0);
                    if (text_dec == 32'd0) begin
                        n_phase = dcsp_pkg::PH_OPCODE;
                    end
                end
                dcsp_pkg::PH_PARAM: begin
                    n_acc        = acc_shift;
                    n_bytes_left = bl_dec;
                    if (bl_dec == 3'd0) begin
                        o_result_valid = 1'b1;
                        o_result.value = pval;
                        if (id_check && pval != dcsp_pkg::DVI_ID) begin
                            n_halted            = 1'b1;
                            o_result.kind       = dcsp_pkg::KIND_ERROR;
                            o_result.error_code = dcsp_pkg::ERR_BAD_ID;
                            o_result.last       = 1'b1;
                        end else if (page_check && pval != r_prev_page) begin
                            n_halted            = 1'b1;
                            o_result.kind       = dcsp_pkg::KIND_ERROR;
                            o_result.error_code = dcsp_pkg::ERR_PAGE_PTR;
                            o_result.last       = 1'b1;
                        end else begin
                            if (page_check && r_opcode == dcsp_pkg::OP_BOP) begin
                                n_pages     = (r_pages != 16'hFFFF) ? r_pages + 16'd1 : r_pages;
                                n_prev_page = r_cmd_start;
                                o_result.page_count = n_pages;
                            end
                            if (dcsp_pkg::in_group(r_opcode, dcsp_pkg::OP_FNT_DEF1) &&
                                r_slot == dcsp_pkg::SLOT_FNT_AREA) begin
                                n_area_hold = pval[7:0];
                            end
                            o_result.kind = dcsp_pkg::KIND_PARAM;
                            o_result.last = (next_len.len == 3'd0) && (text_len == 32'd0);
                            if (text_len != 32'd0) begin
                                n_phase     = dcsp_pkg::PH_TEXT;
                                n_text_left = text_len;
                            end else if (next_len.len != 3'd0) begin
                                n_slot       = slot_inc;
                                n_bytes_left = next_len.len;
                                n_acc        = 32'd0;
                            end else begin
                                n_phase = dcsp_pkg::PH_OPCODE;
                            end
                        end
                    end
                end
                default: begin
                    // A new command opens on this byte.
                    n_cmd_start                = r_byte_pos;
                    n_opcode                   = i_data_byte;
                    n_slot                     = 4'd0;
                    o_result.opcode            = i_data_byte;
                    o_result.param_index       = 4'd0;
                    o_result.command_position  = r_byte_pos;
                    if (i_data_byte >= dcsp_pkg::OP_FIRST_UNDEF) begin
                        n_halted            = 1'b1;
                        o_result_valid      = 1'b1;
                        o_result.kind       = dcsp_pkg::KIND_ERROR;
                        o_result.error_code = dcsp_pkg::ERR_UNDEF_OP;
                        o_result.last       = 1'b1;
                    end else if (op_len.len == 3'd0) begin
                        n_phase        = dcsp_pkg::PH_OPCODE;
                        o_result_valid = 1'b1;
                        o_result.last  = 1'b1;
                    end else begin
                        n_phase      = dcsp_pkg::PH_PARAM;
                        n_bytes_left = op_len.len;
                        n_acc        = 32'd0;
                    end
                end
            endcase
        end
    end

    // Once halted, the parser stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("parser left the halted state without reset");

    // A halted parser does not advance its byte position.
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> $stable(r_byte_pos))
        else $error("byte position moved while halted");

    // Parameter bytes are always counted down from a nonzero length.
    a_param_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dcsp_pkg::PH_PARAM && !r_halted) |-> (r_bytes_left != 3'd0))
        else $error("parameter phase with no bytes left");

endmodule

`default_nettype wire

FILE: src/dcsp_out_buf.sv
// Two-entry result buffer (output register plus skid register) for the
// DVI command stream parser. Depends on dcsp_pkg.
`default_nettype none

module dcsp_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dcsp_pkg::t_result i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output dcsp_pkg::t_result      o_data,
    input  wire logic              i_ready
);

    logic              r_out_valid;
    logic              r_skid_valid;
    dcsp_pkg::t_result r_out;
    dcsp_pkg::t_result r_skid;
    logic              head_free;

    assign head_free = !r_out_valid || i_ready;
    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (head_free) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= r_skid_valid && i_push;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_out <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    // The skid register is only filled behind a full output register.
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without output entry");

    // A held skid entry is not dropped while the output stays blocked.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid entry lost under stall");

endmodule

`default_nettype wire

FILE: src/dvi_command_stream_parser_top.sv
// Top level of the DVI command stream parser: decode core and result buffer.
// Depends on dcsp_pkg, dcsp_core and dcsp_out_buf.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+---------------------------------
//  in       | input     | i_in_valid / o_in_ready    | i_data_byte
//  out      | output    | o_out_valid / i_out_ready  | o_opcode .. o_last (nine fields)
//
// Each item is one byte of the DVI stream; the parser takes one item per cycle while input
// ready is high. A result, when an item causes one, is registered by the edge that accepts
// the item, into the output register, or into the skid register behind a waiting result.
// Reset is synchronous and active low; it returns the parser to awaiting an opcode.
// A two-entry output buffer lets items be accepted while a result waits; input ready
// drops only when both entries are full. After an error no item causes a result until reset.
`default_nettype none

module dvi_command_stream_parser_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_data_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_opcode,
    output logic [1:0]              o_kind,
    output logic [3:0]              o_param_index,
    output logic signed [31:0]      o_value,
    output logic [7:0]              o_text_byte,
    output logic [1:0]              o_error_code,
    output logic [15:0]             o_page_count,
    output logic [31:0]             o_command_position,
    output logic                    o_last
);

    logic              accept;
    logic              core_valid;
    dcsp_pkg::t_result core_result;
    dcsp_pkg::t_result out_result;

    // An item is taken whenever the buffer has room; every result fits.
    assign accept = i_in_valid && o_in_ready;

    dcsp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .o_result_valid (core_valid),
        .o_result       (core_result)
    );

    dcsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && core_valid),
        .i_data  (core_result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_data  (out_result),
        .i_ready (i_out_ready)
    );

    assign o_opcode           = out_result.opcode;
    assign o_kind             = out_result.kind;
    assign o_param_index      = out_result.param_index;
    assign o_value            = out_result.value;
    assign o_text_byte        = out_result.text_byte;
    assign o_error_code       = out_result.error_code;
    assign o_page_count       = out_result.page_count;
    assign o_command_position = out_result.command_position;
    assign o_last             = out_result.last;

endmodule

`default_nettype wire
